/* rtl/fmkj_pkg.sv */
// fmkj_pkg: shared constants, types and codes of the frame/metadata key join
// used by the top, csr and seq modules of the block, no dependencies
`default_nettype none

package fmkj_pkg;

   localparam int FRAME_DEPTH = 2;
   localparam int META_DEPTH  = 8;

   localparam int FQ_DEPTH = FRAME_DEPTH + 1;
   localparam int MQ_DEPTH = META_DEPTH + 1;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int MQ_AW    = $clog2(MQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
   localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);

   localparam int KEY_W      = 32;
   localparam int HANDLE_W   = 32;
   localparam int ENTRY_W    = KEY_W + HANDLE_W;
   localparam int REQ_DATA_W = KEY_W + HANDLE_W;
   localparam int RSP_DATA_W = KEY_W + 2 * HANDLE_W;

   localparam int NUM_REGS = 2;
   localparam int CSR_AW   = $clog2(4 * NUM_REGS);
   localparam int CSR_IW   = CSR_AW - 2;
   localparam int CSR_DW   = 32;

   localparam logic [CSR_IW-1:0] REG_EMIT_FRAMES = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] REG_EMIT_DROPS  = CSR_IW'(1);

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_META  = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAIR       = 2'd0,
      KIND_FRAME_ONLY = 2'd1,
      KIND_MD_DROP    = 2'd2,
      KIND_REJECT     = 2'd3
   } kind_type;

   typedef struct packed {
      logic emit_drops;
      logic emit_frames;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      kind_type            kind;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] frame_handle;
      logic [HANDLE_W-1:0] metadata_handle;
   } result_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_APPEND = 5'b00010,
      S_READ   = 5'b00100,
      S_DECIDE = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* rtl/frame_metadata_key_join_unit.sv */
// A rejected word's result is staged in the append state and registered in the flush
// state; any other word passes append, read and then decide, which takes one overflow or
// head-match step at a time (a pair pops both heads in one step), before its last result
// is registered in flush. A held output can stall decide and flush. One word at a time:
// the next word is taken only once the unit is back in idle after the previous word.
// Reset (synchronous): both queues empty, report enables set, no result held.
`default_nettype none

module frame_metadata_key_join_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [fmkj_pkg::REQ_DATA_W-1:0]   req_tdata,  // item_key, payload
   input  wire logic                              req_tuser,  // operation
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [fmkj_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // event_key, frame_handle, metadata_handle
   output logic      [1:0]                        rsp_tuser,  // event_kind
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fmkj_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [fmkj_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic      [fmkj_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                                   csr_pready
);
   import fmkj_pkg::*;

   cfg_type cfg;

   fmkj_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fmkj_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/fmkj_ram.sv */
// fmkj_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module fmkj_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/fmkj_csr.sv */
// fmkj_csr: apb register file holding the two report enables
// depends on fmkj_pkg
`default_nettype none

module fmkj_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [fmkj_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [fmkj_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [fmkj_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready,
   output fmkj_pkg::cfg_type                  cfg
);
   import fmkj_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic [CSR_IW-1:0] idx;
   logic              wr;
   logic              rd_bit;

   assign idx        = csr_paddr[CSR_AW-1:2];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr && idx == REG_EMIT_FRAMES) begin
         cfg_in.emit_frames = csr_pwdata[0];
      end
      if (wr && idx == REG_EMIT_DROPS) begin
         cfg_in.emit_drops = csr_pwdata[0];
      end
   end

   always_comb begin
      priority if (idx == REG_EMIT_FRAMES) begin
         rd_bit = cfg_ff.emit_frames;
      end else if (idx == REG_EMIT_DROPS) begin
         rd_bit = cfg_ff.emit_drops;
      end else begin
         rd_bit = 1'b0;
      end
   end

   assign csr_prdata = CSR_DW'(rd_bit);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{emit_drops: 1'b1, emit_frames: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/fmkj_seq.sv */
// fmkj_seq: queue sequencer; two circular queues in rams, ordering check,
// head matching loop, one-deep result staging and output register
// depends on fmkj_pkg and fmkj_ram
`default_nettype none

module fmkj_seq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fmkj_pkg::cfg_type                 cfg,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [fmkj_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [fmkj_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [1:0]                        rsp_tuser,
   output logic                                   rsp_tlast
);
   import fmkj_pkg::*;

   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [HANDLE_W-1:0]  payload_ff, payload_in;

   logic [FQ_AW-1:0]     f_head_ff, f_head_in;
   logic [FQ_CW-1:0]     f_count_ff, f_count_in;
   logic [KEY_W-1:0]     f_last_ff, f_last_in;
   logic [MQ_AW-1:0]     m_head_ff, m_head_in;
   logic [MQ_CW-1:0]     m_count_ff, m_count_in;
   logic [KEY_W-1:0]     m_last_ff, m_last_in;

   logic                 pend_valid_ff, pend_valid_in;
   result_type           pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff, out_in;
   logic                 out_last_ff, out_last_in;

   logic                 f_wr_en, m_wr_en;
   entry_type            wr_entry;
   entry_type            f_head_entry, m_head_entry;
   logic [FQ_AW:0]       f_sum;
   logic [MQ_AW:0]       m_sum;
   logic [FQ_AW-1:0]     f_tail, f_next;
   logic [MQ_AW-1:0]     m_tail, m_next;

   logic                 out_free;
   logic                 reject;
   logic                 have_act, act_emit, pop_f, pop_m, stall;
   result_type           act_res;

   // queue pointers
   assign f_sum  = (FQ_AW+1)'(f_head_ff) + (FQ_AW+1)'(f_count_ff);
   assign m_sum  = (MQ_AW+1)'(m_head_ff) + (MQ_AW+1)'(m_count_ff);
   assign f_tail = (f_sum >= (FQ_AW+1)'(FQ_DEPTH)) ?
                   FQ_AW'(f_sum - (FQ_AW+1)'(FQ_DEPTH)) : f_sum[FQ_AW-1:0];
   assign m_tail = (m_sum >= (MQ_AW+1)'(MQ_DEPTH)) ?
                   MQ_AW'(m_sum - (MQ_AW+1)'(MQ_DEPTH)) : m_sum[MQ_AW-1:0];
   assign f_next = (f_head_ff == FQ_AW'(FQ_DEPTH - 1)) ? '0 : f_head_ff + 1'b1;
   assign m_next = (m_head_ff == MQ_AW'(MQ_DEPTH - 1)) ? '0 : m_head_ff + 1'b1;

   assign wr_entry = '{key: key_ff, handle: payload_ff};

   // read address follows the next head, so the registered read data holds the current head entry
   fmkj_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FQ_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (f_tail),
      .wr_data (wr_entry),
      .rd_addr (f_head_in),
      .rd_data (f_head_entry)
   );

   fmkj_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MQ_DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_tail),
      .wr_data (wr_entry),
      .rd_addr (m_head_in),
      .rd_data (m_head_entry)
   );

   assign out_free = ~out_valid_ff | rsp_tready;

   assign reject = (op_ff == OP_FRAME) ?
                   (f_count_ff != '0 && f_last_ff >= key_ff) :
                   (m_count_ff != '0 && m_last_ff >= key_ff);

   // one queue action per cycle unless stalled by a held output: overflow first, then head compare
   always_comb begin
      have_act = 1'b1;
      pop_f    = 1'b0;
      pop_m    = 1'b0;
      act_emit = 1'b0;
      act_res  = '{kind: KIND_FRAME_ONLY, key: f_head_entry.key,
                   frame_handle: f_head_entry.handle, metadata_handle: '0};
      priority if (f_count_ff > FQ_CW'(FRAME_DEPTH)) begin
         pop_f    = 1'b1;
         act_emit = cfg.emit_frames;
      end else if (m_count_ff > MQ_CW'(META_DEPTH)) begin
         pop_m    = 1'b1;
         act_emit = cfg.emit_drops;
         act_res  = '{kind: KIND_MD_DROP, key: m_head_entry.key,
                      frame_handle: '0, metadata_handle: m_head_entry.handle};
      end else if (f_count_ff != '0 && m_count_ff != '0) begin
         priority if (f_head_entry.key < m_head_entry.key) begin
            pop_f    = 1'b1;
            act_emit = cfg.emit_frames;
         end else if (f_head_entry.key == m_head_entry.key) begin
            pop_f    = 1'b1;
            pop_m    = 1'b1;
            act_emit = cfg.emit_frames;
            act_res.kind            = KIND_PAIR;
            act_res.metadata_handle = m_head_entry.handle;
         end else begin
            pop_m    = 1'b1;
            act_emit = cfg.emit_drops;
            act_res  = '{kind: KIND_MD_DROP, key: m_head_entry.key,
                         frame_handle: '0, metadata_handle: m_head_entry.handle};
         end
      end else begin
         have_act = 1'b0;
      end
   end

   assign stall = have_act & act_emit & pend_valid_ff & ~out_free;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      payload_in    = payload_ff;
      f_head_in     = f_head_ff;
      f_count_in    = f_count_ff;
      f_last_in     = f_last_ff;
      m_head_in     = m_head_ff;
      m_count_in    = m_count_ff;
      m_last_in     = m_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      f_wr_en       = 1'b0;
      m_wr_en       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               key_in     = req_tdata[KEY_W-1:0];
               payload_in = req_tdata[REQ_DATA_W-1:KEY_W];
               state_in   = S_APPEND;
            end
         end
         S_APPEND: begin
            if (reject) begin
               pend_in       = '{kind: KIND_REJECT, key: key_ff,
                                 frame_handle: '0, metadata_handle: '0};
               pend_valid_in = 1'b1;
               state_in      = S_FLUSH;
            end else begin
               if (op_ff == OP_FRAME) begin
                  f_wr_en    = 1'b1;
                  f_count_in = f_count_ff + 1'b1;
                  f_last_in  = key_ff;
               end else begin
                  m_wr_en    = 1'b1;
                  m_count_in = m_count_ff + 1'b1;
                  m_last_in  = key_ff;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!have_act) begin
               state_in = S_FLUSH;
            end else if (!stall) begin
               if (pop_f) begin
                  f_head_in  = f_next;
                  f_count_in = f_count_ff - 1'b1;
               end
               if (pop_m) begin
                  m_head_in  = m_next;
                  m_count_in = m_count_ff - 1'b1;
               end
               if (act_emit) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = pend_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_in       = act_res;
                  pend_valid_in = 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         f_head_ff     <= '0;
         f_count_ff    <= '0;
         m_head_ff     <= '0;
         m_count_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         f_head_ff     <= f_head_in;
         f_count_ff    <= f_count_in;
         m_head_ff     <= m_head_in;
         m_count_ff    <= m_count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      payload_ff  <= payload_in;
      f_last_ff   <= f_last_in;
      m_last_ff   <= m_last_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.metadata_handle, out_ff.frame_handle, out_ff.key};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* tb/tb_frame_metadata_key_join_unit.sv */
// tb_frame_metadata_key_join_unit: self-checking bench for the frame/metadata key join,
// with a driver, a monitor and an internal join predictor over several report-flag settings
// depends on fmkj_pkg and frame_metadata_key_join_unit
`default_nettype none

module tb_frame_metadata_key_join_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fmkj_pkg::*;

   typedef struct {
      logic                op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } join_request;

   typedef struct {
      kind_type            kind;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] frame_handle;
      logic [HANDLE_W-1:0] meta_handle;
      logic                last;
   } join_event;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // item_key, payload
   logic                  req_tuser = 1'b0; // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // event_key, frame_handle, metadata_handle
   logic [1:0]            rsp_tuser;        // event_kind
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   join_request pending_requests[$];
   join_event   expected_events[$];
   join_event   step_events[$];
   entry_type   frame_backlog[$];
   entry_type   meta_backlog[$];
   logic        emit_frames_cfg = 1'b1;
   logic        emit_drops_cfg = 1'b1;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatch_count = 0;
   logic [KEY_W-1:0] gen_key = 32'd64;

   frame_metadata_key_join_unit DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_frame_metadata_key_join_unit NOT OK");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   function automatic void release_frame_alone();
      entry_type f;
      f = frame_backlog[0];
      frame_backlog.delete(0);
      if (emit_frames_cfg)
         step_events.insert(step_events.size(),
                            '{KIND_FRAME_ONLY, f.key, f.handle, '0, 1'b0});
   endfunction

   function automatic void drop_oldest_meta();
      entry_type m;
      m = meta_backlog[0];
      meta_backlog.delete(0);
      if (emit_drops_cfg)
         step_events.insert(step_events.size(),
                            '{KIND_MD_DROP, m.key, '0, m.handle, 1'b0});
   endfunction

   function automatic void predict_join(logic op, logic [KEY_W-1:0] key,
                                        logic [HANDLE_W-1:0] handle);
      entry_type f, m;
      step_events.delete();
      if (op == OP_FRAME) begin
         if (frame_backlog.size() > 0 && frame_backlog[frame_backlog.size()-1].key >= key) begin
            expected_events.insert(expected_events.size(), '{KIND_REJECT, key, '0, '0, 1'b1});
            return;
         end
         frame_backlog.insert(frame_backlog.size(), '{key: key, handle: handle});
         while (frame_backlog.size() > FRAME_DEPTH)
            release_frame_alone();
      end else begin
         if (meta_backlog.size() > 0 && meta_backlog[meta_backlog.size()-1].key >= key) begin
            expected_events.insert(expected_events.size(), '{KIND_REJECT, key, '0, '0, 1'b1});
            return;
         end
         meta_backlog.insert(meta_backlog.size(), '{key: key, handle: handle});
         while (meta_backlog.size() > META_DEPTH)
            drop_oldest_meta();
      end
      while (frame_backlog.size() > 0 && meta_backlog.size() > 0) begin
         if (frame_backlog[0].key < meta_backlog[0].key) begin
            release_frame_alone();
         end else if (frame_backlog[0].key == meta_backlog[0].key) begin
            f = frame_backlog[0];
            frame_backlog.delete(0);
            m = meta_backlog[0];
            meta_backlog.delete(0);
            if (emit_frames_cfg)
               step_events.insert(step_events.size(),
                                  '{KIND_PAIR, f.key, f.handle, m.handle, 1'b0});
         end else begin
            drop_oldest_meta();
         end
      end
      if (step_events.size() > 0)
         step_events[step_events.size()-1].last = 1'b1;
      foreach (step_events[i])
         expected_events.insert(expected_events.size(), step_events[i]);
   endfunction

   // driver
   always @(posedge clock) begin
      join_request nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_join(req_tuser, req_tdata[KEY_W-1:0], req_tdata[REQ_DATA_W-1:KEY_W]);
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_requests[0];
               pending_requests.delete(0);
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= {nxt.handle, nxt.key};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      join_event want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected word kind %0d key %h", rsp_tuser,
                                         rsp_tdata[KEY_W-1:0]));
            end else begin
               want = expected_events[0];
               expected_events.delete(0);
               if (rsp_tuser !== want.kind || rsp_tdata !== {want.meta_handle,
                   want.frame_handle, want.key} || rsp_tlast !== want.last)
                  report_mismatch($sformatf(
                     "got kind %0d data %h last %b, want kind %0d data %h last %b",
                     rsp_tuser, rsp_tdata, rsp_tlast, want.kind,
                     {want.meta_handle, want.frame_handle, want.key}, want.last));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_item(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
      pending_requests.insert(pending_requests.size(), '{op, key, handle});
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_EMIT_FRAMES)
         emit_frames_cfg = value;
      else
         emit_drops_cfg = value;
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_tvalid || expected_events.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // one key slot: frame and/or metadata (or neither) at the current key, in random order
   task automatic push_slot(ref int cnt);
      bit has_f, has_m, meta_first;
      has_f = $urandom_range(99) < 85;
      has_m = $urandom_range(99) < 80;
      meta_first = 1'($urandom_range(1));
      if (has_m && meta_first) begin push_item(OP_META, gen_key, $urandom); cnt++; end
      if (has_f) begin push_item(OP_FRAME, gen_key, $urandom); cnt++; end
      if (has_m && !meta_first) begin push_item(OP_META, gen_key, $urandom); cnt++; end
      gen_key += $urandom_range(1, 4);
   endtask

   task automatic gen_items(int base_idx, int n);
      int cnt, r, len;
      logic [KEY_W-1:0] start_key;
      cnt = 0;
      start_key = base_idx * 32'h3000_0000 + $urandom_range(0, 32'h00FF_FFFF);
      if (start_key > gen_key)
         gen_key = start_key;
      while (cnt < n) begin
         r = $urandom_range(99);
         if (r < 60) begin
            push_slot(cnt);
         end else if (r < 68) begin
            len = $urandom_range(2, 4);
            repeat (len) begin
               push_item(OP_FRAME, gen_key, $urandom);
               gen_key += $urandom_range(1, 3);
               cnt++;
            end
         end else if (r < 78) begin
            len = $urandom_range(3, 10);
            repeat (len) begin
               push_item(OP_META, gen_key, $urandom);
               gen_key += $urandom_range(1, 3);
               cnt++;
            end
         end else if (r < 90) begin
            push_item(1'($urandom_range(1)), $urandom_range(0, gen_key), $urandom);
            cnt++;
         end else begin
            gen_key += $urandom_range(1, 32'h0010_0000);
            push_slot(cnt);
         end
      end
   endtask

   task automatic run_phase(int base_idx, logic ef, logic ed, int send_pct, int recv_pct,
                            int n);
      write_reg(REG_EMIT_FRAMES, ef);
      write_reg(REG_EMIT_DROPS, ed);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      gen_items(base_idx, n);
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // matching, rejects and both overflows from reset
      push_item(OP_META,  32'd0, 32'h0000_0000);
      push_item(OP_FRAME, 32'd0, 32'hFFFF_FFFF);
      push_item(OP_FRAME, 32'd5, 32'hA5A5_A5A5);
      push_item(OP_FRAME, 32'd5, 32'h5A5A_5A5A);
      push_item(OP_FRAME, 32'd3, 32'h0000_0001);
      push_item(OP_FRAME, 32'd6, 32'hFFFF_FFFF);
      push_item(OP_FRAME, 32'd7, 32'h8000_0000);
      push_item(OP_META,  32'd4, 32'hFFFF_FFFF);
      push_item(OP_META,  32'd6, 32'h1234_5678);
      push_item(OP_META,  32'd6, 32'h0000_0000);
      for (int i = 10; i <= 19; i++)
         push_item(OP_META, i, $urandom);
      push_item(OP_META,  32'd19, 32'hFFFF_FFFF);
      push_item(OP_FRAME, 32'd30, 32'h0000_0000);
      push_item(OP_FRAME, 32'd31, 32'hFFFF_FFFF);
      drain();

      run_phase(1, 1'b1, 1'b1, 0, 0, 70);
      run_phase(2, 1'b0, 1'b1, 82, 0, 65);
      run_phase(3, 1'b1, 1'b0, 0, 82, 65);
      run_phase(4, 1'b0, 1'b0, 20, 20, 25);

      write_reg(REG_EMIT_FRAMES, 1'b1);
      write_reg(REG_EMIT_DROPS, 1'b1);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      gen_items(5, 60);
      // top of the key range
      push_item(OP_FRAME, 32'hFFFF_FFFE, 32'h0000_0000);
      push_item(OP_META,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(OP_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(OP_FRAME, 32'hFFFF_FFFF, 32'h0000_0000);
      push_item(OP_FRAME, 32'hFFFF_FFFF, 32'h1111_1111);
      push_item(OP_META,  32'hFFFF_FFFF, 32'h0000_0000);
      push_item(OP_META,  32'hFFFF_FFFF, 32'h2222_2222);
      drain();

      if (mismatch_count == 0)
         $display("tb_frame_metadata_key_join_unit OK");
      else
         $display("tb_frame_metadata_key_join_unit NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
